[design/acfm_pkg.sv]
// Package for the adaptive cumulative frequency model.
// Holds operation and status codes, state machine type and default constants.
package acfm_pkg;
	localparam int NumSymbolsDefault = 256;
	localparam int TimeBitsDefault = 48;
	localparam int CfgIdxBits = 2;
	localparam int CfgDataBits = 32;

	typedef enum logic [1:0] {
		OP_QUERY = 2'd0,
		OP_COUNT = 2'd1,
		OP_HALVE = 2'd2,
		OP_SET   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EARLY    = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_STEP = 2'd0,
		REG_SGAP = 2'd1,
		REG_GGAP = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDLAST,
		S_DECIDE,
		S_CLEAR,
		S_HRD,
		S_HWAIT,
		S_HWR,
		S_APPLY,
		S_SUMRD,
		S_SUMWAIT,
		S_SUMACC,
		S_OUT
	} state_t;
endpackage

[design/acfm_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module acfm_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/adaptive_cumulative_frequency_model_core.sv]
// Top level of the adaptive cumulative frequency model.
// Uses acfm_pkg and acfm_ram.
//
// One word in, one word out. Counts and last-seen times sit in RAMs with a
// registered read. The bounds are summed from symbol 0 up to the addressed
// symbol in three steps per symbol (address, wait, accumulate). Halve adds a
// sweep over all entries (read, wait, write per entry), and a count that clears
// the counts adds a sweep over all counts. After reset a clearing pass over all
// entries loads every count with one and every time with zero; no word is taken
// during it. tdata out is held until taken; the next word is accepted only when
// the previous result is gone and the block is back in idle.
module adaptive_cumulative_frequency_model_core #(
	parameter int SYM_COUNT = acfm_pkg::NumSymbolsDefault,
	parameter int TIME_BITS = acfm_pkg::TimeBitsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// opcode[1:0], symbol[9:2], event_time[57:10], new_count[89:58], zero pad
	input  logic [95:0]                       s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// low_bound[31:0], high_bound[63:32], grand_total[95:64], status[97:96], pad
	output logic [103:0]                      m_tdata,
	input  logic                              cfg_we,
	input  logic [acfm_pkg::CfgIdxBits-1:0]   cfg_index,
	input  logic [acfm_pkg::CfgDataBits-1:0]  cfg_data
);
	localparam int AW = $clog2(SYM_COUNT);
	localparam int CW = AW + 1;

	acfm_pkg::state_t state_q, state_d;

	logic [15:0] step_q;
	logic [31:0] sgap_q, ggap_q;
	logic [TIME_BITS-1:0] prev_time_q;
	logic [31:0] total_q;

	logic [1:0] op_q;
	logic [7:0] sym_q;
	logic [TIME_BITS-1:0] time_q;
	logic [31:0] nv_q;
	logic [1:0] status_q;
	logic [CW-1:0] idx_q;
	logic [31:0] low_q, high_q;
	logic [31:0] cur_q;
	logic init_q;
	logic [103:0] out_q;
	logic out_valid_q;

	logic cnt_we, tim_we;
	logic [AW-1:0] cnt_waddr, cnt_raddr, tim_waddr;
	logic [31:0] cnt_wdata, cnt_rdata;
	logic [TIME_BITS-1:0] tim_wdata, tim_rdata;

	acfm_ram #(.Width(32), .Depth(SYM_COUNT)) u_cnt (
		.clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);
	acfm_ram #(.Width(TIME_BITS), .Depth(SYM_COUNT)) u_tim (
		.clk, .we(tim_we), .waddr(tim_waddr), .wdata(tim_wdata),
		.raddr(AW'(sym_q)), .rdata(tim_rdata)
	);

	logic in_range;
	logic [TIME_BITS-1:0] in_time;
	logic [TIME_BITS:0] dsym, dglob;
	logic do_clear, early;
	logic [32:0] cnt_sum, set_sum;
	logic [31:0] half_val;

	assign in_time = TIME_BITS'(s_tdata[57:10]);
	assign in_range = 32'(sym_q) < 32'(SYM_COUNT);
	assign early = time_q < tim_rdata;
	assign dsym = {1'b0, time_q} - {1'b0, tim_rdata};
	assign dglob = {1'b0, time_q} - {1'b0, prev_time_q};
	assign do_clear = (dsym > (TIME_BITS+1)'(sgap_q)) && (time_q > prev_time_q)
		&& (dglob > (TIME_BITS+1)'(ggap_q));
	assign cnt_sum = (do_clear ? 33'd0 : {1'b0, total_q}) + 33'(step_q);
	// The symbol's count, read at acceptance and captured in S_RDLAST, sits in cur_q.
	assign set_sum = {1'b0, total_q} - {1'b0, cur_q} + {1'b0, nv_q};
	assign half_val = cur_q - {1'b0, cur_q[31:1]};

	assign s_tready = (state_q == acfm_pkg::S_IDLE) && !out_valid_q && !init_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	always_comb begin
		state_d = state_q;
		cnt_we = 1'b0;
		cnt_waddr = idx_q[AW-1:0];
		cnt_wdata = 32'd1;
		cnt_raddr = idx_q[AW-1:0];
		tim_we = 1'b0;
		tim_waddr = idx_q[AW-1:0];
		tim_wdata = '0;
		if (init_q) begin
			cnt_we = 1'b1;
			tim_we = 1'b1;
		end
		unique case (state_q)
			acfm_pkg::S_IDLE: begin
				cnt_raddr = AW'(s_tdata[9:2]);
				if (s_tvalid && s_tready) begin
					state_d = acfm_pkg::S_RDLAST;
				end
			end
			acfm_pkg::S_RDLAST: begin
				cnt_raddr = AW'(sym_q);
				if (!in_range) begin
					state_d = acfm_pkg::S_OUT;
				end else if (op_q == acfm_pkg::OP_HALVE) begin
					state_d = acfm_pkg::S_HRD;
				end else begin
					state_d = acfm_pkg::S_DECIDE;
				end
			end
			acfm_pkg::S_DECIDE: begin
				cnt_waddr = AW'(sym_q);
				tim_waddr = AW'(sym_q);
				state_d = acfm_pkg::S_SUMRD;
				if (op_q == acfm_pkg::OP_COUNT && !early && !cnt_sum[32]) begin
					tim_we = 1'b1;
					tim_wdata = time_q;
					if (do_clear) begin
						state_d = acfm_pkg::S_CLEAR;
					end else begin
						cnt_we = 1'b1;
						cnt_wdata = cur_q + 32'(step_q);
					end
				end else if (op_q == acfm_pkg::OP_SET && !set_sum[32]) begin
					cnt_we = 1'b1;
					cnt_wdata = nv_q;
				end
			end
			acfm_pkg::S_CLEAR: begin
				cnt_we = 1'b1;
				cnt_wdata = (idx_q[AW-1:0] == AW'(sym_q)) ? 32'(step_q) : 32'd0;
				if (32'(idx_q) == 32'(SYM_COUNT - 1)) begin
					state_d = acfm_pkg::S_SUMRD;
				end
			end
			acfm_pkg::S_HRD: state_d = acfm_pkg::S_HWAIT;
			acfm_pkg::S_HWAIT: state_d = acfm_pkg::S_HWR;
			acfm_pkg::S_HWR: begin
				cnt_we = cur_q > 32'd1;
				cnt_wdata = half_val;
				state_d = (32'(idx_q) == 32'(SYM_COUNT - 1)) ?
					acfm_pkg::S_SUMRD : acfm_pkg::S_HRD;
			end
			acfm_pkg::S_APPLY: state_d = acfm_pkg::S_SUMRD;
			acfm_pkg::S_SUMRD: state_d = acfm_pkg::S_SUMWAIT;
			acfm_pkg::S_SUMWAIT: state_d = acfm_pkg::S_SUMACC;
			acfm_pkg::S_SUMACC: begin
				state_d = (idx_q[AW-1:0] == AW'(sym_q)) ?
					acfm_pkg::S_OUT : acfm_pkg::S_SUMRD;
			end
			acfm_pkg::S_OUT: state_d = acfm_pkg::S_IDLE;
			default: state_d = acfm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acfm_pkg::S_IDLE;
			init_q <= 1'b1;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			step_q <= 16'd1;
			sgap_q <= 32'd1000;
			ggap_q <= 32'd1000;
			prev_time_q <= '0;
			total_q <= 32'(SYM_COUNT);
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					acfm_pkg::REG_STEP: step_q <= cfg_data[15:0];
					acfm_pkg::REG_SGAP: sgap_q <= cfg_data;
					acfm_pkg::REG_GGAP: ggap_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (init_q) begin
				if (32'(idx_q) == 32'(SYM_COUNT - 1)) begin
					init_q <= 1'b0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			unique case (state_q)
				acfm_pkg::S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q <= s_tdata[1:0];
						sym_q <= s_tdata[9:2];
						time_q <= in_time;
						nv_q <= s_tdata[89:58];
						status_q <= acfm_pkg::ST_OK;
						idx_q <= '0;
						low_q <= '0;
						high_q <= '0;
					end
				end
				acfm_pkg::S_RDLAST: begin
					cur_q <= cnt_rdata;
					idx_q <= '0;
				end
				acfm_pkg::S_DECIDE: begin
					if (op_q == acfm_pkg::OP_COUNT) begin
						if (early) begin
							status_q <= acfm_pkg::ST_EARLY;
						end else if (cnt_sum[32]) begin
							status_q <= acfm_pkg::ST_OVERFLOW;
						end else begin
							total_q <= cnt_sum[31:0];
							prev_time_q <= time_q;
						end
					end else if (op_q == acfm_pkg::OP_SET) begin
						if (set_sum[32]) begin
							status_q <= acfm_pkg::ST_OVERFLOW;
						end else begin
							total_q <= set_sum[31:0];
						end
					end
				end
				acfm_pkg::S_CLEAR: begin
					idx_q <= (32'(idx_q) == 32'(SYM_COUNT - 1)) ? '0 : idx_q + 1'b1;
				end
				acfm_pkg::S_HWAIT: cur_q <= cnt_rdata;
				acfm_pkg::S_HWR: begin
					if (cur_q > 32'd1) begin
						total_q <= total_q - {1'b0, cur_q[31:1]};
					end
					idx_q <= (32'(idx_q) == 32'(SYM_COUNT - 1)) ? '0 : idx_q + 1'b1;
				end
				acfm_pkg::S_SUMACC: begin
					if (idx_q[AW-1:0] == AW'(sym_q)) begin
						high_q <= low_q + cnt_rdata;
					end else begin
						low_q <= low_q + cnt_rdata;
					end
					idx_q <= idx_q + 1'b1;
				end
				acfm_pkg::S_OUT: begin
					out_q <= {6'd0, status_q, total_q,
						in_range ? high_q : 32'd0, in_range ? low_q : 32'd0};
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule
